// ===== rtl/core/cia_pkg.sv =====
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and codes for the overflow-checked integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

   localparam int unsigned OP_W = 5;
   localparam int unsigned FIELD_W = 64;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_REM  = 5'd3,
      OP_NEG  = 5'd4,  OP_INC  = 5'd5,  OP_DEC  = 5'd6,  OP_AND  = 5'd7,
      OP_OR   = 5'd8,  OP_XOR  = 5'd9,  OP_NOT  = 5'd10, OP_SHR  = 5'd11,
      OP_SHL  = 5'd12, OP_CMP  = 5'd13, OP_BYTE = 5'd14, OP_LNOT = 5'd15,
      OP_LAND = 5'd16, OP_LOR  = 5'd17
   } op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_OVF = 2'd1,
      ST_ERR = 2'd2
   } status_type;

   // Work class decided by the front part.
   typedef enum logic [1:0] {
      CLS_DONE = 2'd0,
      CLS_MUL  = 2'd1,
      CLS_REM  = 2'd2
   } class_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_RUN  = 2'd1,
      BK_FIN  = 2'd2
   } back_state_type;

   typedef struct packed {
      logic [4:0]         operation;
      logic signed [63:0] operand_a;
      logic signed [63:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic [1:0]         status;
   } rsp_type;

   // One queued job: a finished result or a multiply or remainder job with magnitudes.
   typedef struct packed {
      class_type   cls;
      logic        neg;
      logic [63:0] ma;
      logic [63:0] mb;
      rsp_type     rsp;
   } job_type;

endpackage

// ===== rtl/core/cia_front.sv =====
// ----------------------------------------------------------------------------
// cia_front
// Sign-extend operands, finish the combinational operations, classify the rest.
// ----------------------------------------------------------------------------
module cia_front #(
   parameter int unsigned DATA_WIDTH = 64
) (
   input  cia_pkg::req_type req,
   output cia_pkg::job_type job
);

   localparam logic [63:0] WMASK = (DATA_WIDTH == 64) ? {64{1'b1}}
                                   : ((64'd1 << DATA_WIDTH) - 64'd1);
   localparam logic [63:0] WMAX  = WMASK >> 1;

   function automatic logic [63:0] sext(input logic [63:0] v);
      logic [63:0] t;
      t = v & WMASK;
      if (DATA_WIDTH < 64 && t[DATA_WIDTH-1]) t = t | ~WMASK;
      return t;
   endfunction

   logic [63:0] a, b, ma, mb, ms, r, idx;
   logic        na, nb, nbe, ns, ovf, err;
   logic [64:0] sum;
   logic [5:0]  cnt;
   logic [2:0]  bsel;
   cia_pkg::class_type cls;

   always_comb begin
      a   = sext(req.operand_a);
      b   = sext(req.operand_b);
      na  = a[63];
      nb  = b[63];
      ma  = na ? (64'd0 - a) : a;
      mb  = nb ? (64'd0 - b) : b;
      cnt = req.operand_b[5:0];
      idx = (DATA_WIDTH < 64) ? b : req.operand_b;
      r   = '0;
      ovf = 1'b0;
      err = 1'b0;
      cls = cia_pkg::CLS_DONE;
      ns  = 1'b0;
      nbe = nb;
      ms  = mb;
      sum = '0;
      bsel = 3'd7 - idx[2:0];
      // sign-magnitude adder operand select
      case (req.operation)
         cia_pkg::OP_SUB: nbe = ~nb;
         cia_pkg::OP_INC: begin nbe = 1'b0; ms = 64'd1; end
         cia_pkg::OP_DEC: begin nbe = 1'b1; ms = 64'd1; end
         default: ;
      endcase
      if (na == nbe) begin
         sum = {1'b0, ma} + {1'b0, ms};
         ns  = na;
      end else if (ma >= ms) begin
         sum = {1'b0, ma - ms};
         ns  = na;
      end else begin
         sum = {1'b0, ms - ma};
         ns  = nbe;
      end
      case (req.operation)
         cia_pkg::OP_ADD, cia_pkg::OP_SUB, cia_pkg::OP_INC, cia_pkg::OP_DEC: begin
            ovf = sum[64] || (sum[63:0] > WMAX);
            r   = ns ? (64'd0 - sum[63:0]) : sum[63:0];
         end
         cia_pkg::OP_MUL: cls = cia_pkg::CLS_MUL;
         cia_pkg::OP_REM: begin
            if (mb == 64'd0) err = 1'b1;
            else cls = cia_pkg::CLS_REM;
         end
         cia_pkg::OP_NEG: begin
            ovf = ma > WMAX;
            r   = na ? ma : (64'd0 - ma);
         end
         cia_pkg::OP_AND: r = a & b;
         cia_pkg::OP_OR:  r = a | b;
         cia_pkg::OP_XOR: r = a ^ b;
         cia_pkg::OP_NOT: r = sext(~a);
         cia_pkg::OP_SHR: r = $unsigned($signed(a) >>> cnt);
         cia_pkg::OP_SHL: r = sext(a << cnt);
         cia_pkg::OP_CMP: r = ($signed(a) < $signed(b)) ? {64{1'b1}}
                              : ((a == b) ? 64'd0 : 64'd1);
         cia_pkg::OP_BYTE: begin
            if (idx > 64'd7) err = 1'b1;
            else r = {56'd0, a[{bsel, 3'b000} +: 8]};
         end
         cia_pkg::OP_LNOT: r = {63'd0, a == 64'd0};
         cia_pkg::OP_LAND: r = {63'd0, (a != 64'd0) && (b != 64'd0)};
         cia_pkg::OP_LOR:  r = {63'd0, (a != 64'd0) || (b != 64'd0)};
         default: err = 1'b1;
      endcase
      job.cls = cls;
      job.neg = na ^ nb;
      job.ma  = ma;
      job.mb  = mb;
      job.rsp.value  = (ovf || err) ? 64'sd0 : $signed(r);
      job.rsp.status = err ? cia_pkg::ST_ERR : (ovf ? cia_pkg::ST_OVF : cia_pkg::ST_OK);
   end

endmodule

// ===== rtl/core/cia_queue.sv =====
// ----------------------------------------------------------------------------
// cia_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module cia_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cia_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output cia_pkg::job_type head
);

   cia_pkg::job_type mem_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_job;
   end

   assign head  = mem_ff[rp_ff];
   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("pop from empty queue");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("bad queue count");

endmodule

// ===== rtl/core/cia_back.sv =====
// ----------------------------------------------------------------------------
// cia_back
// Shift-add multiply and shift-subtract remainder, one bit a cycle.
// ----------------------------------------------------------------------------
module cia_back #(
   parameter int unsigned DATA_WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  cia_pkg::job_type head,
   output logic             pop,
   output logic             rsp_valid,
   output cia_pkg::rsp_type rsp
);

   localparam logic [63:0] WMASK = (DATA_WIDTH == 64) ? {64{1'b1}}
                                   : ((64'd1 << DATA_WIDTH) - 64'd1);
   localparam logic [63:0] WMAX  = WMASK >> 1;

   cia_pkg::back_state_type st_ff, st_in;
   logic [5:0]  bit_ff, bit_in;
   logic [64:0] acc_ff, acc_in;   // product or partial remainder
   logic        ovf_ff, ovf_in;
   logic [64:0] acc2, diff;
   logic [63:0] mag;
   logic        bitv, load, last;
   cia_pkg::rsp_type rsp_ff, rsp_in;
   logic        vld_ff, vld_in;

   assign bitv = head.mb[bit_ff] ;
   assign last = bit_ff == 6'd0;
   assign load = (st_ff == cia_pkg::BK_IDLE) && !empty
                 && (head.cls != cia_pkg::CLS_DONE);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         cia_pkg::BK_IDLE: if (load) st_in = cia_pkg::BK_RUN;
         cia_pkg::BK_RUN:  if (last) st_in = cia_pkg::BK_FIN;
         cia_pkg::BK_FIN:  st_in = cia_pkg::BK_IDLE;
         default:          st_in = cia_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      bit_in = bit_ff;
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      acc2   = '0;
      diff   = '0;
      if (load) begin
         bit_in = 6'd63;
         acc_in = '0;
         ovf_in = 1'b0;
      end else if (st_ff == cia_pkg::BK_RUN) begin
         bit_in = bit_ff - 6'd1;
         if (head.cls == cia_pkg::CLS_MUL) begin
            // MSB-first: acc = 2*acc + (bit ? ma : 0); track bound on WMAX
            acc2 = {acc_ff[63:0], 1'b0};
            ovf_in = ovf_ff || acc_ff[64] || acc_ff[63];
            acc_in = acc2 + (bitv ? {1'b0, head.ma} : 65'd0);
            if (acc_in > {1'b0, WMAX}) ovf_in = 1'b1;
            if (ovf_in) acc_in = '0;
         end else begin
            acc2 = {acc_ff[63:0], head.ma[bit_ff]};
            diff = acc2 - {1'b0, head.mb};
            acc_in = diff[64] ? acc2 : diff;
         end
      end
   end

   always_comb begin
      mag = acc_ff[63:0];
      pop = 1'b0;
      vld_in = 1'b0;
      rsp_in = head.rsp;
      if ((st_ff == cia_pkg::BK_IDLE) && !empty && head.cls == cia_pkg::CLS_DONE) begin
         pop = 1'b1;
         vld_in = 1'b1;
      end else if (st_ff == cia_pkg::BK_FIN) begin
         pop = 1'b1;
         vld_in = 1'b1;
         if (ovf_ff || mag > WMAX) begin
            rsp_in.value  = 64'sd0;
            rsp_in.status = cia_pkg::ST_OVF;
         end else begin
            rsp_in.value  = $signed(head.neg ? (64'd0 - mag) : mag);
            rsp_in.status = cia_pkg::ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= cia_pkg::BK_IDLE;
         vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
      acc_ff <= acc_in;
      ovf_ff <= ovf_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp = rsp_ff;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop while empty");
   a_fin_follows_run: assert property (@(posedge clock) disable iff (reset)
      st_ff == cia_pkg::BK_FIN |-> $past(st_ff) == cia_pkg::BK_RUN)
      else $error("finish without run");
   a_rsp_after_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid) else $error("word lost");

endmodule

// ===== rtl/core/checked_int64_alu_top.sv =====
// ----------------------------------------------------------------------------
// checked_int64_alu_top
// Overflow-checked signed integer ALU with a decoupled front and back end.
// ----------------------------------------------------------------------------
// Issue a word by raising start while busy is low. Simple operations are
// finished in the front end and return their word through the queue and the
// back end's result register; multiply and remainder run in the
// one-bit-per-cycle shift-add/shift-subtract unit in the back end. A two-entry
// queue holds words between the front end and the back end; busy rises while
// the queue is full. Each result word shows on rsp_word for exactly one cycle
// with rsp_strobe high; the receiver cannot stall, so sample it in that cycle.
// Overflow or error forces value to zero.
module checked_int64_alu_top #(
   parameter int unsigned DATA_WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cia_pkg::req_type req_word,
   output logic             rsp_strobe,
   output cia_pkg::rsp_type rsp_word
);

   cia_pkg::job_type job, head;
   logic full, empty, pop, push;

   // classify and finish simple words at the front
   cia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (.req(req_word), .job(job));

   assign busy = full;
   assign push = start && !full;

   // hold pending jobs
   cia_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(job), .full(full),
      .pop(pop), .empty(empty), .head(head)
   );

   // advance long jobs bit by bit
   cia_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock(clock), .reset(reset), .empty(empty), .head(head), .pop(pop),
      .rsp_valid(rsp_strobe), .rsp(rsp_word)
   );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the overflow-checked integer ALU. Drives directed corner
// words and then random words with random gaps, predicts every result from
// an independent model of the ALU, and checks each strobed result in order.
// ----------------------------------------------------------------------------
class alu_scoreboard;
   cia_pkg::rsp_type pending[$];
   int mismatches;

   function new();
      mismatches = 0;
   endfunction

   // Derive the expected word for an accepted request and hold it.
   function void note_request(cia_pkg::req_type rq);
      pending.push_back(alu_predict(rq));
   endfunction

   // Compare a strobed result with the oldest expectation.
   function void check_result(cia_pkg::rsp_type got);
      cia_pkg::rsp_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h/%0d", got.value, got.status);
         return;
      end
      want = pending.pop_front();
      if (got.value !== want.value || got.status !== want.status) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %h/%0d actual %h/%0d",
                     want.value, want.status, got.value, got.status);
      end
   endfunction

   // Signed sum of two sign-magnitude values, checked against the symmetric range.
   static function cia_pkg::status_type signed_sum(bit na, bit [63:0] ma, bit nb,
                                                   bit [63:0] mb, output bit [63:0] r);
      bit [64:0] s;
      bit ns;
      bit [63:0] ms;
      r = '0;
      if (na == nb) begin
         s = {1'b0, ma} + {1'b0, mb};
         if (s[64]) return cia_pkg::ST_OVF;
         ms = s[63:0];
         ns = na;
      end else if (ma >= mb) begin
         ms = ma - mb;
         ns = na;
      end else begin
         ms = mb - ma;
         ns = nb;
      end
      if (ms[63]) return cia_pkg::ST_OVF;
      r = ns ? -ms : ms;
      return cia_pkg::ST_OK;
   endfunction

   static function cia_pkg::rsp_type alu_predict(cia_pkg::req_type rq);
      bit [63:0] a, b, ma, mb, r, m;
      bit na, nb;
      bit [127:0] prod;
      int cnt;
      cia_pkg::status_type st;
      cia_pkg::rsp_type out;
      a = rq.operand_a;
      b = rq.operand_b;
      na = a[63];
      nb = b[63];
      ma = na ? -a : a;
      mb = nb ? -b : b;
      r = '0;
      st = cia_pkg::ST_OK;
      cnt = int'(b[5:0]);
      case (rq.operation)
         cia_pkg::OP_ADD: st = signed_sum(na, ma, nb, mb, r);
         cia_pkg::OP_SUB: st = signed_sum(na, ma, !nb, mb, r);
         cia_pkg::OP_MUL: begin
            prod = ma * mb;
            if (prod[127:63] != 0) st = cia_pkg::ST_OVF;
            else r = (na != nb) ? -prod[63:0] : prod[63:0];
         end
         cia_pkg::OP_REM: begin
            if (mb == 0) st = cia_pkg::ST_ERR;
            else begin
               m = ma % mb;
               if (m[63]) st = cia_pkg::ST_OVF;
               else r = (na != nb) ? -m : m;
            end
         end
         cia_pkg::OP_NEG: begin
            if (ma[63]) st = cia_pkg::ST_OVF;
            else r = -a;
         end
         cia_pkg::OP_INC: st = signed_sum(na, ma, 1'b0, 64'd1, r);
         cia_pkg::OP_DEC: st = signed_sum(na, ma, 1'b1, 64'd1, r);
         cia_pkg::OP_AND: r = a & b;
         cia_pkg::OP_OR: r = a | b;
         cia_pkg::OP_XOR: r = a ^ b;
         cia_pkg::OP_NOT: r = ~a;
         cia_pkg::OP_SHR: r = $signed(a) >>> cnt;
         cia_pkg::OP_SHL: r = a << cnt;
         cia_pkg::OP_CMP: r = ($signed(a) < $signed(b)) ? '1 : (a == b ? 64'd0 : 64'd1);
         cia_pkg::OP_BYTE: begin
            if (b > 7) st = cia_pkg::ST_ERR;
            else r = (a >> (8 * (7 - b[2:0]))) & 64'hff;
         end
         cia_pkg::OP_LNOT: r = {63'd0, a == 0};
         cia_pkg::OP_LAND: r = {63'd0, a != 0 && b != 0};
         cia_pkg::OP_LOR: r = {63'd0, a != 0 || b != 0};
         default: st = cia_pkg::ST_ERR;
      endcase
      if (st != cia_pkg::ST_OK) r = '0;
      out.value = r;
      out.status = st;
      return out;
   endfunction
endclass

module tb_top;

   localparam int CYCLE_LIMIT = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   cia_pkg::req_type req_word = '0;
   logic rsp_strobe;
   cia_pkg::rsp_type rsp_word;

   alu_scoreboard board = new();
   int cycles = 0;

   checked_int64_alu_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   always #10 clock = ~clock;

   // Note accepted words and check strobed results at the rising edge.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) board.note_request(req_word);
         if (rsp_strobe) board.check_result(rsp_word);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 80);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Present one word from a falling edge and hold it until accepted.
   task automatic issue_word(logic [4:0] op, logic [63:0] a, logic [63:0] b);
      req_word.operation = op;
      req_word.operand_a = a;
      req_word.operand_b = b;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic idle_cycles(int n);
      repeat (n) @(negedge clock);
   endtask

   // Random operand: corners, small values or full-width noise.
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return 64'h8000_0000_0000_0001;
         3: return 64'(int'($urandom_range(0, 20)) - 10);
         4: return {{32{1'b0}}, $urandom()} >> $urandom_range(0, 31);
         5: return -({{32{1'b0}}, $urandom()});
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   localparam logic [63:0] MAXP = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] MINN = 64'h8000_0000_0000_0000;

   initial begin
      logic [4:0] op;
      logic [63:0] a, b;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed corners: range edges, most negative operand, zero divisor,
      // byte index edges, shift counts at the top of the range and beyond the width, an unused code.
      issue_word(cia_pkg::OP_ADD, MAXP, 64'd1);
      issue_word(cia_pkg::OP_ADD, -MAXP, -64'd1);
      issue_word(cia_pkg::OP_SUB, -MAXP, 64'd1);
      issue_word(cia_pkg::OP_SUB, MINN, -64'd1);
      issue_word(cia_pkg::OP_MUL, 64'h1_0000_0000, 64'h8000_0000);
      issue_word(cia_pkg::OP_MUL, MINN, 64'd0);
      issue_word(cia_pkg::OP_MUL, -64'd3, 64'd5);
      issue_word(cia_pkg::OP_REM, 64'd7, 64'd0);
      issue_word(cia_pkg::OP_REM, MINN, -64'd3);
      issue_word(cia_pkg::OP_REM, -64'd7, 64'd3);
      issue_word(cia_pkg::OP_NEG, MINN, 64'd0);
      issue_word(cia_pkg::OP_INC, MAXP, 64'd0);
      issue_word(cia_pkg::OP_DEC, -MAXP, 64'd0);
      issue_word(cia_pkg::OP_AND, MINN, '1);
      issue_word(cia_pkg::OP_OR, 64'h5555, MINN);
      issue_word(cia_pkg::OP_XOR, '1, 64'h1234);
      issue_word(cia_pkg::OP_NOT, MAXP, 64'd0);
      issue_word(cia_pkg::OP_SHR, MINN, 64'd127);
      issue_word(cia_pkg::OP_SHL, 64'd1, 64'd63);
      issue_word(cia_pkg::OP_CMP, MINN, MAXP);
      issue_word(cia_pkg::OP_BYTE, 64'h0123_4567_89ab_cdef, 64'd0);
      issue_word(cia_pkg::OP_BYTE, -64'd2, 64'd7);
      issue_word(cia_pkg::OP_BYTE, 64'd5, '1);
      issue_word(cia_pkg::OP_LNOT, 64'd0, 64'd0);
      issue_word(cia_pkg::OP_LAND, 64'd3, 64'd0);
      issue_word(cia_pkg::OP_LOR, 64'd0, 64'd0);
      issue_word(5'd31, 64'd1, 64'd1);

      // Pause until every expected word has come back.
      while (board.pending.size() != 0) @(negedge clock);

      // Random words with random gaps; hold off once more midway.
      for (int i = 0; i < 1800; i++) begin
         op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                           : 5'($urandom_range(0, 17));
         a = pick_operand();
         b = pick_operand();
         if (op == cia_pkg::OP_BYTE && $urandom_range(0, 2) != 0)
            b = 64'($urandom_range(0, 8));
         issue_word(op, a, b);
         if (i == 900) while (board.pending.size() != 0) @(negedge clock);
         if (i % 50 < 40) idle_cycles(gap_length());
      end

      while (board.pending.size() != 0) @(negedge clock);
      idle_cycles(150);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
